### sv/bmbd_pkg.sv
// shared types and constants for the banked memory bus decoder
package bmbd_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    FWD_NONE = 2'd0,
    FWD_CART = 2'd1,
    FWD_TIMER = 2'd2,
    FWD_DISP = 2'd3
  } fwd_t;

  // store selected by a decoded access
  typedef enum logic [3:0] {
    SEL_NONE, SEL_WRAM, SEL_VRAM, SEL_OAM, SEL_HRAM, SEL_SOUND,
    SEL_BGPAL, SEL_OBJPAL, SEL_REG
  } sel_t;

  localparam logic [15:0] ADDR_JOYP = 16'hFF00;
  localparam logic [15:0] ADDR_SB   = 16'hFF01;
  localparam logic [15:0] ADDR_SC   = 16'hFF02;
  localparam logic [15:0] ADDR_IF   = 16'hFF0F;
  localparam logic [15:0] ADDR_KEY1 = 16'hFF4D;
  localparam logic [15:0] ADDR_VBK  = 16'hFF4F;
  localparam logic [15:0] ADDR_BGPI = 16'hFF68;
  localparam logic [15:0] ADDR_BGPD = 16'hFF69;
  localparam logic [15:0] ADDR_OBPI = 16'hFF6A;
  localparam logic [15:0] ADDR_OBPD = 16'hFF6B;
  localparam logic [15:0] ADDR_SVBK = 16'hFF70;
  localparam logic [15:0] ADDR_IE   = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [9:0]  tick_cycles;
    logic        oam_dma_busy;
    logic [3:0]  action_buttons;
    logic [3:0]  direction_buttons;
  } bus_req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  forward_target;
    logic [15:0] forward_address;
    logic        forward_write;
    logic [7:0]  forward_data;
    logic [4:0]  pending_interrupts;
  } bus_rsp_t;

endpackage

### sv/bmbd_if.sv
// valid/ready channel carrying one payload item
interface bmbd_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/banked_memory_bus_decoder_top.sv
// banked memory bus decoder top level
//
// One bus access (read, write or tick) per item. An accepted item is decoded,
// its memory read issued and its register and palette index writes made in
// the same cycle; the next cycle the synchronous RAM data comes back and the
// result is placed in an output register. An item passes through decode and
// RAM issue, then data return, and no new item is taken until the block is
// back in idle with the output register empty or being taken.
// After reset a clearing pass zeroes every store, one entry per cycle, with a
// counter over the larger of WRAM_BANKS*4096 and 16384 entries (32768 with the
// default), during which no item is taken.
module banked_memory_bus_decoder_top
  import bmbd_pkg::*;
#(
  parameter int WRAM_BANKS    = 8,
  parameter int SERIAL_PERIOD = 512
) (
  input logic clk,
  input logic rst,
  bmbd_if.sink   in_ch,
  bmbd_if.source out_ch
);

  localparam int WRAM_DEPTH = WRAM_BANKS * 4096;
  localparam int WAW        = $clog2(WRAM_DEPTH);
  localparam int CLR_DEPTH  = (WRAM_DEPTH > 16384) ? WRAM_DEPTH : 16384;
  localparam int CLR_W      = $clog2(CLR_DEPTH);
  localparam logic [9:0] SERIAL_LOAD = 10'(SERIAL_PERIOD);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_DATA} state_t;

  // memories
  logic [7:0] wram [WRAM_DEPTH];
  logic [7:0] vram [16384];
  logic [7:0] oam [160];
  logic [7:0] hram [128];
  logic [7:0] snd [48];
  logic [7:0] bgpal [64];
  logic [7:0] obpal [64];

  state_t     state;
  logic [CLR_W-1:0] clr_cnt;

  // registers
  logic [7:0] bg_palette_index, obj_palette_index;
  logic [1:0] joypad_select;
  logic [7:0] serial_byte, serial_control, speed_switch;
  logic [9:0] serial_countdown;
  logic [4:0] irq_flags, irq_enable;
  logic       vram_bank_sel;
  logic [2:0] wram_bank_sel;

  // pending item from decode stage
  bus_req_t   req;
  sel_t       psel;
  logic       pwr;
  logic [1:0] pfwd;
  logic [7:0] reg_rd;

  bus_rsp_t   rsp;
  logic       rsp_valid;

  bus_req_t   cur;
  logic       acc;
  logic       is_rw, is_wr;
  logic [15:0] a;
  sel_t       dsel;
  logic [1:0] dfwd;
  logic [WAW-1:0] wa;
  logic [13:0] va;
  logic [7:0] oa;
  logic [6:0] ha;
  logic [5:0] sa, bpa, opa;
  logic [2:0] bank_raw, bank;
  logic [3:0] joy_b;
  logic [7:0] reg_rd_next;
  logic [7:0] wram_q, vram_q, oam_q, hram_q, snd_q, bgpal_q, obpal_q;
  logic       clearing;
  logic [CLR_W-1:0] ci;
  logic       ci_in_wram;

  assign cur   = in_ch.data;
  assign in_ch.ready = (state == ST_IDLE) && (!rsp_valid || out_ch.ready);
  assign acc   = in_ch.valid && in_ch.ready;
  assign a     = cur.address;
  assign is_rw = (cur.operation == OP_READ) || (cur.operation == OP_WRITE);
  assign is_wr = cur.operation == OP_WRITE;
  assign clearing = state == ST_CLEAR;
  assign ci    = clr_cnt;
  assign ci_in_wram = {1'b0, ci} < (CLR_W + 1)'(WRAM_DEPTH);

  // address decode
  always_comb begin
    dsel = SEL_NONE;
    dfwd = FWD_NONE;
    if (!is_rw) begin
      dsel = SEL_NONE;
    end else if (cur.oam_dma_busy) begin
      if (a >= 16'hFF80 && a != 16'hFFFF) dsel = SEL_HRAM;
    end else if (a < 16'h8000 || (a >= 16'hA000 && a <= 16'hBFFF)) begin
      dfwd = FWD_CART;
    end else if (a <= 16'h9FFF) begin
      dsel = SEL_VRAM;
    end else if (a >= 16'hC000 && a <= 16'hFDFF) begin
      dsel = SEL_WRAM;
    end else if (a >= 16'hFE00 && a <= 16'hFE9F) begin
      dsel = SEL_OAM;
    end else if (a <= 16'hFEFF) begin
      dsel = SEL_NONE;
    end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
      dfwd = FWD_TIMER;
    end else if ((a >= 16'hFF40 && a <= 16'hFF4B) || (a >= 16'hFF51 && a <= 16'hFF55)) begin
      dfwd = FWD_DISP;
    end else if ((a >= 16'hFF10 && a <= 16'hFF14) || (a >= 16'hFF16 && a <= 16'hFF1E) ||
                 (a >= 16'hFF20 && a <= 16'hFF26) || (a >= 16'hFF30 && a <= 16'hFF3F)) begin
      dsel = SEL_SOUND;
    end else if (a >= 16'hFF80 && a != 16'hFFFF) begin
      dsel = SEL_HRAM;
    end else if (a == ADDR_BGPD) begin
      dsel = SEL_BGPAL;
    end else if (a == ADDR_OBPD) begin
      dsel = SEL_OBJPAL;
    end else begin
      dsel = SEL_REG;
    end
  end

  // store addresses
  always_comb begin
    // bank select folded to the bank count, one constant per select value
    unique case (wram_bank_sel)
      3'd0: bank_raw = 3'(0 % WRAM_BANKS);
      3'd1: bank_raw = 3'(1 % WRAM_BANKS);
      3'd2: bank_raw = 3'(2 % WRAM_BANKS);
      3'd3: bank_raw = 3'(3 % WRAM_BANKS);
      3'd4: bank_raw = 3'(4 % WRAM_BANKS);
      3'd5: bank_raw = 3'(5 % WRAM_BANKS);
      3'd6: bank_raw = 3'(6 % WRAM_BANKS);
      3'd7: bank_raw = 3'(7 % WRAM_BANKS);
    endcase
    bank     = (bank_raw == 3'd0) ? 3'd1 : bank_raw;
    if (!a[12]) wa = WAW'({4'd0, a[11:0]});
    else wa = WAW'({1'b0, bank, a[11:0]});
    va  = {vram_bank_sel, a[12:0]};
    oa  = a[7:0];
    ha  = a[6:0];
    sa  = 6'(a[7:0] - 8'h10);
    bpa = bg_palette_index[5:0];
    opa = obj_palette_index[5:0];
  end

  // register read value
  always_comb begin
    joy_b = 4'hF;
    if (!joypad_select[1]) joy_b = joy_b & cur.action_buttons;
    if (!joypad_select[0]) joy_b = joy_b & cur.direction_buttons;
    unique case (a)
      ADDR_JOYP: reg_rd_next = {2'b11, joypad_select, joy_b};
      ADDR_SB:   reg_rd_next = serial_byte;
      ADDR_SC:   reg_rd_next = serial_control;
      ADDR_IF:   reg_rd_next = {3'b111, irq_flags};
      ADDR_KEY1: reg_rd_next = speed_switch | 8'h7E;
      ADDR_VBK:  reg_rd_next = {7'h7F, vram_bank_sel};
      ADDR_SVBK: reg_rd_next = {5'h1F, wram_bank_sel};
      ADDR_BGPI: reg_rd_next = bg_palette_index;
      ADDR_OBPI: reg_rd_next = obj_palette_index;
      ADDR_IE:   reg_rd_next = {3'b000, irq_enable};
      default:   reg_rd_next = 8'hFF;
    endcase
  end

  // memory ports: write on accept or during clearing, registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (ci_in_wram) wram[ci[WAW-1:0]] <= 8'h00;
    end else if (acc && is_wr && dsel == SEL_WRAM) wram[wa] <= cur.write_data;
    wram_q <= wram[wa];
  end
  always_ff @(posedge clk) begin
    if (clearing) vram[ci[13:0]] <= 8'h00;
    else if (acc && is_wr && dsel == SEL_VRAM) vram[va] <= cur.write_data;
    vram_q <= vram[va];
  end
  always_ff @(posedge clk) begin
    if (clearing) oam[ci[7:0]] <= 8'h00;
    else if (acc && is_wr && dsel == SEL_OAM) oam[oa] <= cur.write_data;
    oam_q <= oam[oa];
  end
  always_ff @(posedge clk) begin
    if (clearing) hram[ci[6:0]] <= 8'h00;
    else if (acc && is_wr && dsel == SEL_HRAM) hram[ha] <= cur.write_data;
    hram_q <= hram[ha];
  end
  always_ff @(posedge clk) begin
    if (clearing) snd[ci[5:0]] <= 8'h00;
    else if (acc && is_wr && dsel == SEL_SOUND) snd[sa] <= cur.write_data;
    snd_q <= snd[sa];
  end
  always_ff @(posedge clk) begin
    if (clearing) bgpal[ci[5:0]] <= 8'h00;
    else if (acc && is_wr && dsel == SEL_BGPAL) bgpal[bpa] <= cur.write_data;
    bgpal_q <= bgpal[bpa];
  end
  always_ff @(posedge clk) begin
    if (clearing) obpal[ci[5:0]] <= 8'h00;
    else if (acc && is_wr && dsel == SEL_OBJPAL) obpal[opa] <= cur.write_data;
    obpal_q <= obpal[opa];
  end

  // control state, registers and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      rsp_valid <= 1'b0;
      bg_palette_index <= '0;
      obj_palette_index <= '0;
      joypad_select <= 2'b11;
      serial_byte <= '0;
      serial_control <= '0;
      serial_countdown <= '0;
      irq_flags <= '0;
      irq_enable <= '0;
      speed_switch <= '0;
      vram_bank_sel <= 1'b0;
      wram_bank_sel <= '0;
    end else begin
      if (out_ch.ready) rsp_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (acc) begin
            state  <= ST_DATA;
            req    <= cur;
            psel   <= dsel;
            pwr    <= is_wr;
            pfwd   <= dfwd;
            reg_rd <= reg_rd_next;
            if (cur.operation == OP_TICK && serial_countdown != 10'd0 &&
                cur.tick_cycles != 10'd0) begin
              if (cur.tick_cycles >= serial_countdown) begin
                serial_countdown <= '0;
                serial_control[7] <= 1'b0;
                irq_flags[3] <= 1'b1;
                serial_byte <= 8'hFF;
              end else begin
                serial_countdown <= serial_countdown - cur.tick_cycles;
              end
            end
            if (is_wr && dsel == SEL_REG) begin
              unique case (a)
                ADDR_JOYP: joypad_select <= cur.write_data[5:4];
                ADDR_SB:   serial_byte <= cur.write_data;
                ADDR_SC: begin
                  serial_control <= cur.write_data;
                  if (cur.write_data[7] && cur.write_data[0])
                    serial_countdown <= SERIAL_LOAD;
                end
                ADDR_IF:   irq_flags <= cur.write_data[4:0];
                ADDR_KEY1: speed_switch <= {speed_switch[7], 6'd0, cur.write_data[0]};
                ADDR_VBK:  vram_bank_sel <= cur.write_data[0];
                ADDR_SVBK: wram_bank_sel <= cur.write_data[2:0];
                ADDR_BGPI: bg_palette_index <= cur.write_data;
                ADDR_OBPI: obj_palette_index <= cur.write_data;
                ADDR_IE:   irq_enable <= cur.write_data[4:0];
                default: ;
              endcase
            end
            // palette auto-increment
            if (is_wr && dsel == SEL_BGPAL && bg_palette_index[7])
              bg_palette_index <= {2'b10, 6'(bg_palette_index[5:0] + 6'd1)};
            if (is_wr && dsel == SEL_OBJPAL && obj_palette_index[7])
              obj_palette_index <= {2'b10, 6'(obj_palette_index[5:0] + 6'd1)};
          end
        end
        ST_DATA: begin
          state <= ST_IDLE;
          rsp_valid <= 1'b1;
          rsp.forward_target <= pfwd;
          rsp.forward_address <= (pfwd != FWD_NONE) ? req.address : 16'h0000;
          rsp.forward_write <= (pfwd != FWD_NONE) && pwr;
          rsp.forward_data <= ((pfwd != FWD_NONE) && pwr) ? req.write_data : 8'h00;
          rsp.pending_interrupts <= irq_flags;
          if (req.operation != OP_READ) begin
            rsp.read_data <= 8'hFF;
          end else begin
            case (psel)
              SEL_WRAM:   rsp.read_data <= wram_q;
              SEL_VRAM:   rsp.read_data <= vram_q;
              SEL_OAM:    rsp.read_data <= oam_q;
              SEL_HRAM:   rsp.read_data <= hram_q;
              SEL_SOUND:  rsp.read_data <= snd_q;
              SEL_BGPAL:  rsp.read_data <= bgpal_q;
              SEL_OBJPAL: rsp.read_data <= obpal_q;
              SEL_REG:    rsp.read_data <= reg_rd;
              default:    rsp.read_data <= 8'hFF;
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid = rsp_valid;
  assign out_ch.data  = rsp;

`ifndef SYNTHESIS
  // no item taken while the clearing pass runs
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ch.ready) else $error("accept during clear");
  // every accepted item raises the result valid once its data step has run
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> ##1 rsp_valid) else $error("result missing");
  // a forwarded access never reports a read byte
  a_fwd_rd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.forward_target != FWD_NONE |-> rsp.read_data == 8'hFF)
    else $error("forward with data");
  // a tick never forwards
  a_tick_nofwd: assert property (@(posedge clk) disable iff (rst)
    acc && cur.operation == OP_TICK |=> pfwd == FWD_NONE) else $error("tick forwarded");
`endif

endmodule
